[rtl/core/smpq_pkg.sv]
// shared types and codes of the sorted min-priority queue
package smpq_pkg;

  localparam int unsigned KEY_W = 17;

  // request kinds on the input side
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [15:0] heuristic_cost;
    logic [15:0] path_cost;
    logic [15:0] handle;
  } entry_t;

  // state one cell shows to its neighbours
  typedef struct packed {
    logic   valid;
    logic   ge;
    entry_t entry;
    key_t   key;
  } link_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t entry;
    key_t   key;
  } cmd_t;

endpackage

[rtl/core/smpq_cell.sv]
// one slot of the sorted chain: holds an entry and shifts with its neighbours
module smpq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  smpq_pkg::cmd_t  cmd,
  input  smpq_pkg::link_t from_left,
  input  smpq_pkg::link_t from_right,
  output smpq_pkg::link_t own
);
  import smpq_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  key_t   key_r, key_nxt;
  logic   cond;
  logic   ge;

  // new entry belongs at or before this slot; head only on a strictly smaller key
  assign cond = IS_HEAD ? (cmd.key < key_r) : (key_r >= cmd.key);
  assign ge   = !valid_r || cond;

  // next contents: hold, shift from a neighbour or take the new entry
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    key_nxt   = key_r;
    if (cmd.remove) begin
      valid_nxt = from_right.valid;
      entry_nxt = from_right.entry;
      key_nxt   = from_right.key;
    end else if (cmd.insert) begin
      if (from_left.ge) begin
        valid_nxt = from_left.valid;
        entry_nxt = from_left.entry;
        key_nxt   = from_left.key;
      end else if (ge) begin
        valid_nxt = 1'b1;
        entry_nxt = cmd.entry;
        key_nxt   = cmd.key;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    key_r   <= key_nxt;
  end

  assign own = '{valid: valid_r, ge: ge, entry: entry_r, key: key_r};

endmodule

[rtl/core/sorted_min_priority_queue.sv]
// Sorted min-priority queue as a chain of compare-and-shift cells.
// An accepted request's result lands in the output register in the next cycle.
// One request per cycle unless the output stalls; all cells compare and shift together.
// Reset (synchronous, rst_n low) empties the queue and drops any pending result.
// Stored payloads are not cleared; only the occupancy flags are.
module sorted_min_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // item_handle[15:0], path_cost[31:16], heuristic_cost[47:32]
  input  logic        in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // out_handle[15:0], out_path_cost[31:16],
                                 // out_heuristic_cost[47:32]
  output logic [2:0]  out_tuser  // status[1:0], now_empty[2]
);
  import smpq_pkg::*;

  link_t  links [CAPACITY];
  link_t  head_left;
  link_t  tail_right;
  cmd_t   cmd;
  entry_t new_entry;
  key_t   new_key;
  logic   accept;
  logic   full;
  logic   empty;
  logic   is_insert;

  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  // handshake: the output register frees the input side
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // request decode
  assign new_entry = entry_t'(in_tdata);
  assign new_key   = key_t'({1'b0, new_entry.path_cost}) + key_t'({1'b0, new_entry.heuristic_cost});
  assign is_insert = (in_tuser == ACT_INSERT);
  assign full      = links[CAPACITY-1].valid;
  assign empty     = !links[0].valid;

  assign cmd = '{insert: accept && is_insert && !full,
                 remove: accept && (in_tuser == ACT_REMOVE) && !empty,
                 entry:  new_entry,
                 key:    new_key};

  // chain ends
  assign head_left  = '0;
  assign tail_right = '0;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      smpq_cell #(.IS_HEAD(1'b1)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .from_left  (head_left),
        .from_right (links[i+1]),
        .own        (links[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      smpq_cell #(.IS_HEAD(1'b0)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .from_left  (links[i-1]),
        .from_right (tail_right),
        .own        (links[i])
      );
    end else begin : g_mid
      smpq_cell #(.IS_HEAD(1'b0)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .from_left  (links[i-1]),
        .from_right (links[i+1]),
        .own        (links[i])
      );
    end
  end

  // result formation
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (is_insert) begin
        out_user_nxt = {1'b0, (full ? ST_FULL : ST_OK)};
      end else if (empty) begin
        out_user_nxt = {1'b1, ST_EMPTY};
      end else begin
        out_data_nxt = 48'(links[0].entry);
        out_user_nxt = {!links[1].valid, ST_OK};
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[tb/tb_sorted_min_priority_queue.sv]
// sorted min-priority queue testbench: directed and random requests checked by a shadow queue
module tb_sorted_min_priority_queue;
  import smpq_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TARGET  = 1800;
  localparam int HOLD_LENGTH    = 300;
  localparam int MAX_REPORTS    = 40;

  typedef struct {
    logic   action;
    entry_t entry;
  } request_t;

  typedef struct {
    logic [1:0] status;
    entry_t     entry;
    logic       now_empty;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // item_handle[15:0], path_cost[31:16], heuristic_cost[47:32]
  logic        in_tuser = ACT_INSERT;  // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // out_handle[15:0], out_path_cost[31:16], out_heuristic_cost[47:32]
  logic [2:0]  out_tuser;  // status[1:0], now_empty[2]

  request_t pending_requests[$];
  result_t  due_results[$];
  entry_t   shadow_entries[$];
  request_t in_flight;

  int n_accepted = 0;
  int n_results = 0;
  int n_mismatches = 0;
  int send_gap = 0;
  int send_burst = 0;
  int stall_left = 0;
  int recv_burst = 0;
  int hold_cycles = 0;
  int next_hold_at = 250;
  int quiet_cycles = 0;

  sorted_min_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic key_t cost_key(entry_t e);
    return key_t'(e.path_cost) + key_t'(e.heuristic_cost);
  endfunction

  // apply an accepted request to the shadow queue and record the result it must give
  task automatic apply_to_shadow(request_t rq);
    result_t r;
    key_t    k;
    int      pos;
    r.status = ST_OK;
    r.entry = '0;
    if (rq.action == ACT_INSERT) begin
      if (shadow_entries.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        k = cost_key(rq.entry);
        // a key equal to the head's lands just behind the head
        if (shadow_entries.size() == 0 || k < cost_key(shadow_entries[0])) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < shadow_entries.size() && cost_key(shadow_entries[pos]) < k) pos++;
        end
        shadow_entries.insert(pos, rq.entry);
      end
    end else begin
      if (shadow_entries.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.entry = shadow_entries.pop_front();
      end
    end
    r.now_empty = (shadow_entries.size() == 0);
    due_results.push_back(r);
  endtask

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    n_mismatches++;
    if (n_mismatches <= MAX_REPORTS)
      $display("mismatch in result %0d: %s is %h, expected %h", n_results, field, got, want);
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  function automatic entry_t make_entry(logic [15:0] handle, logic [15:0] pcost,
                                        logic [15:0] hcost);
    entry_t e;
    e.handle = handle;
    e.path_cost = pcost;
    e.heuristic_cost = hcost;
    return e;
  endfunction

  // narrow costs give many equal keys, wide ones cover every bit
  function automatic entry_t random_entry();
    logic [15:0] base;
    if ($urandom_range(0, 99) < 60) begin
      base = 16'($urandom_range(0, 3) * 16'h4000);
      return make_entry(16'($urandom), base | 16'($urandom_range(0, 7)),
                        16'($urandom_range(0, 7)));
    end
    return make_entry(16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic void add_request(logic action, entry_t e);
    request_t rq;
    rq.action = action;
    rq.entry = e;
    pending_requests.push_back(rq);
  endfunction

  // gaps between requests: mostly none or short, now and then long, with unbroken bursts
  function int pick_send_gap();
    int r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_burst = $urandom_range(30, 100);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function int pick_stall();
    int r;
    if (recv_burst > 0) begin
      recv_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      recv_burst = $urandom_range(30, 100);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_to_shadow(in_flight);
        n_accepted <= n_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_flight = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= in_flight.action;
          in_tdata <= in_flight.entry;
          send_gap = pick_send_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the receiver so that the queue backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (n_accepted >= next_hold_at) begin
      hold_cycles <= HOLD_LENGTH;
      next_hold_at <= next_hold_at + 700;
    end
  end

  // result ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_stall();
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    entry_t  got;
    if (rst_n && out_tvalid && out_tready) begin
      got = entry_t'(out_tdata);
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, tdata[15:0]", got.handle, 16'h0);
      end else begin
        want = due_results.pop_front();
        check_field("status", 16'(out_tuser[1:0]), 16'(want.status));
        check_field("out_handle", got.handle, want.entry.handle);
        check_field("out_path_cost", got.path_cost, want.entry.path_cost);
        check_field("out_heuristic_cost", got.heuristic_cost, want.entry.heuristic_cost);
        check_field("now_empty", 16'(out_tuser[2]), 16'(want.now_empty));
      end
      n_results <= n_results + 1;
    end
  end

  // watchdog on cycles with no request and no result moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** sorted_min_priority_queue: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int total;
    int phase_len;
    int insert_pct;
    int i;

    // directed: removal from empty, extremes, equal keys at and after the head
    add_request(ACT_REMOVE, make_entry(16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_request(ACT_INSERT, make_entry(16'h0000, 16'h0000, 16'h0000));
    add_request(ACT_INSERT, make_entry(16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_request(ACT_INSERT, make_entry(16'h0001, 16'h0000, 16'h0000));
    add_request(ACT_INSERT, make_entry(16'h00A1, 16'd100, 16'd0));
    add_request(ACT_INSERT, make_entry(16'h00A2, 16'd0, 16'd100));
    add_request(ACT_INSERT, make_entry(16'h00A3, 16'd50, 16'd50));
    add_request(ACT_INSERT, make_entry(16'h5555, 16'hAAAA, 16'h5555));
    add_request(ACT_INSERT, make_entry(16'hAAAA, 16'h5555, 16'hAAAA));
    add_request(ACT_INSERT, make_entry(16'h8000, 16'h8000, 16'h8000));
    for (i = 0; i < 10; i++) add_request(ACT_REMOVE, make_entry(16'h0, 16'h0, 16'h0));

    // random phases: filling past full, draining past empty, and mixed
    total = 0;
    while (total < RANDOM_TARGET) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 90;
        1: insert_pct = 10;
        default: insert_pct = 50;
      endcase
      phase_len = $urandom_range(60, 120);
      for (i = 0; i < phase_len; i++) begin
        add_request(($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE,
                    random_entry());
      end
      total += phase_len;
    end
    total = pending_requests.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (n_mismatches == 0) begin
      $display("** sorted_min_priority_queue: PASSED **");
    end else begin
      $display("** sorted_min_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/smpq_pkg.sv
rtl/core/smpq_cell.sv
rtl/core/sorted_min_priority_queue.sv
tb/tb_sorted_min_priority_queue.sv
